@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sphere cell triangulator
// Field layouts, fixed-point widths, pipeline latencies and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int COORD_W    = 16;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int MAX_DIV    = 1024;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLAR_BANDS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AZIMUTH_SECTORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOWER_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Z_UPPER_LIMIT   = 2'd3;

    // angle divider: (n << 32) / d, 33 quotient bits, 2 per stage, 1 in the first
    localparam int QUO_W   = 33;
    localparam int DIV_LAT = 1 + (QUO_W - 1) / 2;

    // CORDIC in Q2.30
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 32;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int ROUND_SH     = 30 - FRAC_BITS;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    // square root of 1 - z^2
    localparam int SQRT_STEPS = FRAC_BITS + 1;
    localparam int SQRT_W     = 2 * FRAC_BITS + 2;
    localparam int ROOT_W     = FRAC_BITS + 1;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [COORD_W-1:0] FX_ONE = 16'sd1 <<< FRAC_BITS;

    typedef struct packed {
        logic [IDX_W-1:0] polar_index;
        logic [IDX_W-1:0] azimuth_index;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] az;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by_coord;
        logic signed [COORD_W-1:0] bz;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic                      last_of_cell;
    } t_out;

    typedef struct packed {
        logic [CNT_W-1:0]          polar_bands;
        logic [CNT_W-1:0]          azimuth_sectors;
        logic signed [COORD_W-1:0] z_lower_limit;
        logic signed [COORD_W-1:0] z_upper_limit;
    } t_cfg;

    // one classified cell waiting for the back end
    typedef struct packed {
        logic [IDX_W-1:0] polar_index;
        logic [IDX_W-1:0] azimuth_index;
        logic             pole;
    } t_cell;

    typedef struct packed {
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] s;
    } t_sincos;

    // arctangent of 2^-i as a fraction of a full turn (2^32 per turn)
    function automatic logic [CORDIC_W-1:0] atan_turn(input int i);
        case (i)
            0:       atan_turn = 32'h20000000;
            1:       atan_turn = 32'h12E4051E;
            2:       atan_turn = 32'h09FB385B;
            3:       atan_turn = 32'h051111D4;
            4:       atan_turn = 32'h028B0D43;
            5:       atan_turn = 32'h0145D7E1;
            6:       atan_turn = 32'h00A2F61E;
            7:       atan_turn = 32'h00517C55;
            8:       atan_turn = 32'h0028BE53;
            9:       atan_turn = 32'h00145F2F;
            10:      atan_turn = 32'h000A2F98;
            11:      atan_turn = 32'h000517CC;
            12:      atan_turn = 32'h00028BE6;
            13:      atan_turn = 32'h000145F3;
            14:      atan_turn = 32'h0000A2F9;
            15:      atan_turn = 32'h0000517C;
            default: atan_turn = '0;
        endcase
    endfunction

endpackage

@@ rtl/sct_front.sv @@
// ----------------------------------------------------------------------------
// sct_front: config registers and input classification
// Holds the four config registers, drops cells with an out-of-range index or
// count and tags pole bands before pushing into the cell queue.
// ----------------------------------------------------------------------------
module sct_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sct_pkg::t_in                   i_in_data,
    input  logic                           i_cfg_we,
    input  logic [sct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sct_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sct_pkg::t_cfg                  o_cfg,
    input  logic                           i_q_full,
    output logic                           o_push,
    output sct_pkg::t_cell                 o_cell
);
    import sct_pkg::*;

    t_cfg r_cfg;
    logic counts_ok, idx_ok, pole;
    logic [CNT_W-1:0] t_ext, p_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polar_bands     <= CNT_W'(16);
            r_cfg.azimuth_sectors <= CNT_W'(32);
            r_cfg.z_lower_limit   <= -FX_ONE;
            r_cfg.z_upper_limit   <= FX_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_POLAR_BANDS:     r_cfg.polar_bands     <= i_cfg_data[CNT_W-1:0];
                REG_AZIMUTH_SECTORS: r_cfg.azimuth_sectors <= i_cfg_data[CNT_W-1:0];
                REG_Z_LOWER_LIMIT:   r_cfg.z_lower_limit   <= signed'(i_cfg_data);
                REG_Z_UPPER_LIMIT:   r_cfg.z_upper_limit   <= signed'(i_cfg_data);
            endcase
        end
    end

    always_comb begin
        t_ext     = {1'b0, i_in_data.polar_index};
        p_ext     = {1'b0, i_in_data.azimuth_index};
        counts_ok = (r_cfg.polar_bands != '0) && (r_cfg.polar_bands <= CNT_W'(MAX_DIV))
                 && (r_cfg.azimuth_sectors != '0)
                 && (r_cfg.azimuth_sectors <= CNT_W'(MAX_DIV));
        idx_ok    = (t_ext < r_cfg.polar_bands) && (p_ext < r_cfg.azimuth_sectors);
        pole      = (t_ext == '0) || (t_ext == r_cfg.polar_bands - CNT_W'(1));
    end

    assign o_cfg                = r_cfg;
    assign o_in_ready           = !i_q_full;
    assign o_push               = i_in_valid && !i_q_full && counts_ok && idx_ok;
    assign o_cell.polar_index   = i_in_data.polar_index;
    assign o_cell.azimuth_index = i_in_data.azimuth_index;
    assign o_cell.pole          = pole;

endmodule

@@ rtl/sct_queue.sv @@
// ----------------------------------------------------------------------------
// sct_queue: short cell queue between front and back end
// ----------------------------------------------------------------------------
module sct_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sct_pkg::t_cell i_cell,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sct_pkg::t_cell o_head
);
    import sct_pkg::*;

    t_cell                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_cnt;
    logic                   do_pop;

    assign o_full  = (r_cnt == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            if (i_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cell;
    end

endmodule

@@ rtl/sct_divider.sv @@
// ----------------------------------------------------------------------------
// sct_divider: pipelined angle divider
// (num << 32) / den with num <= den; stage 0 gives one bit, the others two.
// ----------------------------------------------------------------------------
module sct_divider (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [sct_pkg::CNT_W-1:0]  i_num,
    input  logic [sct_pkg::CNT_W-1:0]  i_den,
    output logic [sct_pkg::QUO_W-1:0]  o_quo
);
    import sct_pkg::*;

    logic [CNT_W-1:0] r_rem [DIV_LAT];
    logic [QUO_W-1:0] r_quo [DIV_LAT];
    logic [CNT_W:0]   c_s1 [DIV_LAT];
    logic [CNT_W:0]   c_s2 [DIV_LAT];
    logic             first_ge;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [CNT_W:0] div_step(input logic [CNT_W-1:0] rem,
                                                input logic [CNT_W-1:0] den);
        logic [CNT_W:0] sh;
        sh = {rem, 1'b0};
        if (sh >= {1'b0, den}) div_step = {1'b1, CNT_W'(sh - {1'b0, den})};
        else div_step = {1'b0, sh[CNT_W-1:0]};
    endfunction

    assign first_ge = (i_num >= i_den);

    always_comb begin
        c_s1[0] = '0;
        c_s2[0] = '0;
        for (int k = 1; k < DIV_LAT; k++) begin
            c_s1[k] = div_step(r_rem[k-1], i_den);
            c_s2[k] = div_step(c_s1[k][CNT_W-1:0], i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= first_ge ? (i_num - i_den) : i_num;
            r_quo[0] <= QUO_W'(first_ge);
            for (int k = 1; k < DIV_LAT; k++) begin
                r_rem[k] <= c_s2[k][CNT_W-1:0];
                r_quo[k] <= {r_quo[k-1][QUO_W-3:0], c_s1[k][CNT_W], c_s2[k][CNT_W]};
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];

endmodule

@@ rtl/sct_cordic.sv @@
// ----------------------------------------------------------------------------
// sct_cordic: pipelined rotation CORDIC, cosine and sine of a turn fraction
// One iteration per stage, then rounding and quadrant mapping.
// ----------------------------------------------------------------------------
module sct_cordic (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [sct_pkg::CORDIC_W-1:0]  i_phase,
    output sct_pkg::t_sincos              o_sc
);
    import sct_pkg::*;

    typedef enum logic [1:0] {Q_FIRST, Q_SECOND, Q_THIRD, Q_FOURTH} t_quad;

    logic signed [CORDIC_W-1:0] r_x [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_y [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] r_z [CORDIC_STEPS];
    t_quad                      r_quad [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_x [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_y [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_z [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_nx [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_ny [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] c_nz [CORDIC_STEPS];
    logic signed [COORD_W-1:0]  fx, fy;
    t_sincos                    r_sc;

    function automatic logic signed [COORD_W-1:0] to_fx(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0] t;
        t = (signed'({v[CORDIC_W-1], v}) + ((CORDIC_W+1)'(1) <<< (ROUND_SH - 1)))
            >>> ROUND_SH;
        if (t > (CORDIC_W+1)'(FX_ONE)) to_fx = FX_ONE;
        else if (t < -(CORDIC_W+1)'(FX_ONE)) to_fx = -FX_ONE;
        else to_fx = t[COORD_W-1:0];
    endfunction

    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                c_x[i] = CORDIC_GAIN;
                c_y[i] = '0;
                c_z[i] = signed'({2'b00, i_phase[CORDIC_W-3:0]});
            end else begin
                c_x[i] = r_x[i-1];
                c_y[i] = r_y[i-1];
                c_z[i] = r_z[i-1];
            end
            if (!c_z[i][CORDIC_W-1]) begin
                c_nx[i] = c_x[i] - (c_y[i] >>> i);
                c_ny[i] = c_y[i] + (c_x[i] >>> i);
                c_nz[i] = c_z[i] - signed'(atan_turn(i));
            end else begin
                c_nx[i] = c_x[i] + (c_y[i] >>> i);
                c_ny[i] = c_y[i] - (c_x[i] >>> i);
                c_nz[i] = c_z[i] + signed'(atan_turn(i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quad[0] <= t_quad'(i_phase[CORDIC_W-1:CORDIC_W-2]);
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_x[i] <= c_nx[i];
                r_y[i] <= c_ny[i];
                r_z[i] <= c_nz[i];
                if (i > 0) r_quad[i] <= r_quad[i-1];
            end
        end
    end

    assign fx = to_fx(r_x[CORDIC_STEPS-1]);
    assign fy = to_fx(r_y[CORDIC_STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r_quad[CORDIC_STEPS-1])
                Q_FIRST:  begin r_sc.c <= fx;  r_sc.s <= fy;  end
                Q_SECOND: begin r_sc.c <= -fy; r_sc.s <= fx;  end
                Q_THIRD:  begin r_sc.c <= -fx; r_sc.s <= -fy; end
                Q_FOURTH: begin r_sc.c <= fy;  r_sc.s <= -fx; end
            endcase
        end
    end

    assign o_sc = r_sc;

endmodule

@@ rtl/sct_sqrt.sv @@
// ----------------------------------------------------------------------------
// sct_sqrt: pipelined integer square root, rounded to nearest
// One result bit per stage, rounding in the last stage.
// ----------------------------------------------------------------------------
module sct_sqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [sct_pkg::SQRT_W-1:0]  i_rad,
    output logic [sct_pkg::ROOT_W-1:0]  o_root
);
    import sct_pkg::*;

    logic [SQRT_W-1:0] r_v [SQRT_STEPS];
    logic [SQRT_W-1:0] r_r [SQRT_STEPS];
    logic [SQRT_W-1:0] c_v [SQRT_STEPS];
    logic [SQRT_W-1:0] c_r [SQRT_STEPS];
    logic [SQRT_W-1:0] c_bit [SQRT_STEPS];
    logic [ROOT_W-1:0] r_root;

    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            c_v[k]   = (k == 0) ? i_rad : r_v[k-1];
            c_r[k]   = (k == 0) ? '0 : r_r[k-1];
            c_bit[k] = SQRT_W'(1) << (2 * FRAC_BITS - 2 * k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                if (c_v[k] >= c_r[k] + c_bit[k]) begin
                    r_v[k] <= c_v[k] - (c_r[k] + c_bit[k]);
                    r_r[k] <= (c_r[k] >> 1) + c_bit[k];
                end else begin
                    r_v[k] <= c_v[k];
                    r_r[k] <= c_r[k] >> 1;
                end
            end
            if (r_v[SQRT_STEPS-1] > r_r[SQRT_STEPS-1])
                r_root <= ROOT_W'(r_r[SQRT_STEPS-1] + SQRT_W'(1));
            else
                r_root <= r_r[SQRT_STEPS-1][ROOT_W-1:0];
        end
    end

    assign o_root = r_root;

endmodule

@@ rtl/sct_back.sv @@
// ----------------------------------------------------------------------------
// sct_back: cell geometry pipeline and triangle emitter
// Angles, sine/cosine, z clipping, vertex products, then one or two triangle
// beats per cell. The whole pipe advances together when the cell stage
// can take a new cell.
// ----------------------------------------------------------------------------
module sct_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sct_pkg::t_cfg  i_cfg,
    input  logic           i_q_empty,
    input  sct_pkg::t_cell i_head,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sct_pkg::t_out  o_out_data
);
    import sct_pkg::*;

    localparam int L1_LEN = DIV_LAT + CORDIC_LAT;

    typedef struct packed {
        logic                      pole;
        logic                      up;
        logic                      lo;
        logic signed [COORD_W-1:0] ct0;
        logic signed [COORD_W-1:0] st0;
        logic signed [COORD_W-1:0] ct1;
        logic signed [COORD_W-1:0] st1;
        logic signed [COORD_W-1:0] cp0;
        logic signed [COORD_W-1:0] sp0;
        logic signed [COORD_W-1:0] cp1;
        logic signed [COORD_W-1:0] sp1;
    } t_geo;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vtx;

    logic adv;

    // angle dividers
    logic [CNT_W-1:0] t_n0, t_n1, p_n0, p_n1;
    logic [QUO_W-1:0] q_t0, q_t1, q_p0, q_p1;

    assign t_n0 = {1'b0, i_head.polar_index};
    assign t_n1 = t_n0 + CNT_W'(1);
    assign p_n0 = {1'b0, i_head.azimuth_index};
    assign p_n1 = p_n0 + CNT_W'(1);

    sct_divider u_div_t0 (.i_clk, .i_en(adv), .i_num(t_n0), .i_den(i_cfg.polar_bands),
                          .o_quo(q_t0));
    sct_divider u_div_t1 (.i_clk, .i_en(adv), .i_num(t_n1), .i_den(i_cfg.polar_bands),
                          .o_quo(q_t1));
    sct_divider u_div_p0 (.i_clk, .i_en(adv), .i_num(p_n0), .i_den(i_cfg.azimuth_sectors),
                          .o_quo(q_p0));
    sct_divider u_div_p1 (.i_clk, .i_en(adv), .i_num(p_n1), .i_den(i_cfg.azimuth_sectors),
                          .o_quo(q_p1));

    // theta is half a turn per band count, phi a full turn wrapping to zero
    t_sincos sc_t0, sc_t1, sc_p0, sc_p1;

    sct_cordic u_cor_t0 (.i_clk, .i_en(adv), .i_phase(q_t0[QUO_W-1:1]), .o_sc(sc_t0));
    sct_cordic u_cor_t1 (.i_clk, .i_en(adv), .i_phase(q_t1[QUO_W-1:1]), .o_sc(sc_t1));
    sct_cordic u_cor_p0 (.i_clk, .i_en(adv), .i_phase(q_p0[CORDIC_W-1:0]), .o_sc(sc_p0));
    sct_cordic u_cor_p1 (.i_clk, .i_en(adv), .i_phase(q_p1[CORDIC_W-1:0]), .o_sc(sc_p1));

    // sideband alongside dividers and CORDICs
    logic r_l1_v    [L1_LEN];
    logic r_l1_pole [L1_LEN];

    // clip stage
    logic signed [COORD_W-1:0] ct0, st0, ct1, st1, zmin, zmax, zsel, zsat;
    logic                      drop, up, lo;
    logic                      r_a_v;
    t_geo                      r_a_geo;
    logic signed [COORD_W-1:0] r_a_z;

    always_comb begin
        ct0  = sc_t0.c;
        st0  = sc_t0.s;
        ct1  = sc_t1.c;
        st1  = sc_t1.s;
        zmin = i_cfg.z_lower_limit;
        zmax = i_cfg.z_upper_limit;
        drop = (ct1 > zmax) || (ct0 < zmin);
        up   = (zmax <= ct0) && (zmax > ct1);
        lo   = !up && (zmin <= ct0) && (zmin > ct1);
        zsel = up ? zmax : zmin;
        if (zsel > FX_ONE) zsat = FX_ONE;
        else if (zsel < -FX_ONE) zsat = -FX_ONE;
        else zsat = zsel;
    end

    // radicand stage: 1 - z^2
    logic signed [2*COORD_W-1:0] zsq;
    logic                        r_b_v;
    t_geo                        r_b_geo;
    logic [SQRT_W-1:0]           r_b_rad;
    logic [ROOT_W-1:0]           root;

    assign zsq = r_a_z * r_a_z;

    sct_sqrt u_sqrt (.i_clk, .i_en(adv), .i_rad(r_b_rad), .o_root(root));

    logic r_l2_v   [SQRT_LAT];
    t_geo r_l2_geo [SQRT_LAT];

    // product stage: clipped edge takes the limit and its root
    t_geo                        g;
    logic signed [COORD_W-1:0]   root_s, s0, s1, c0, c1;
    logic                        r_d_v, r_d_pole;
    logic signed [COORD_W-1:0]   r_d_c0, r_d_c1;
    logic signed [2*COORD_W-1:0] r_d_x00, r_d_y00, r_d_x01, r_d_y01;
    logic signed [2*COORD_W-1:0] r_d_x10, r_d_y10, r_d_x11, r_d_y11;

    always_comb begin
        g      = r_l2_geo[SQRT_LAT-1];
        root_s = signed'({1'b0, root});
        s0     = g.up ? root_s : g.st0;
        c0     = g.up ? i_cfg.z_upper_limit : g.ct0;
        s1     = g.lo ? root_s : g.st1;
        c1     = g.lo ? i_cfg.z_lower_limit : g.ct1;
    end

    // cell stage and emitter
    function automatic logic signed [COORD_W-1:0] fx_round(
        input logic signed [2*COORD_W-1:0] p);
        logic signed [2*COORD_W-1:0] t;
        t = (p + ((2*COORD_W)'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        fx_round = t[COORD_W-1:0];
    endfunction

    function automatic t_out make_tri(input t_vtx va, input t_vtx vb, input t_vtx vc,
                                      input logic last);
        t_out o;
        o.ax = va.x; o.ay = va.y;       o.az = va.z;
        o.bx = vb.x; o.by_coord = vb.y; o.bz = vb.z;
        o.cx = vc.x; o.cy = vc.y;       o.cz = vc.z;
        o.last_of_cell = last;
        make_tri = o;
    endfunction

    t_vtx v00, v01, v10, v11;
    logic r_cell_v, r_cell_two, r_phase, r_out_v;
    t_out r_cell_first, r_cell_second, r_out;
    logic out_free, cell_fin;

    always_comb begin
        v00 = '{x: fx_round(r_d_x00), y: fx_round(r_d_y00), z: r_d_c0};
        v01 = '{x: fx_round(r_d_x01), y: fx_round(r_d_y01), z: r_d_c1};
        v10 = '{x: fx_round(r_d_x10), y: fx_round(r_d_y10), z: r_d_c0};
        v11 = '{x: fx_round(r_d_x11), y: fx_round(r_d_y11), z: r_d_c1};
    end

    assign out_free = !r_out_v || i_out_ready;
    assign cell_fin = r_cell_v && out_free && (!r_cell_two || r_phase);
    assign adv      = !r_cell_v || cell_fin;
    assign o_pop    = adv && !i_q_empty;

    // control: valid bits of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L1_LEN; k++) r_l1_v[k] <= 1'b0;
            for (int k = 0; k < SQRT_LAT; k++) r_l2_v[k] <= 1'b0;
            r_a_v    <= 1'b0;
            r_b_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_cell_v <= 1'b0;
            r_phase  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_free) r_out_v <= r_cell_v;
            if (r_cell_v && out_free) r_phase <= r_cell_two && !r_phase;
            if (adv) begin
                r_l1_v[0] <= !i_q_empty;
                for (int k = 1; k < L1_LEN; k++) r_l1_v[k] <= r_l1_v[k-1];
                r_a_v     <= r_l1_v[L1_LEN-1] && !drop;
                r_b_v     <= r_a_v;
                r_l2_v[0] <= r_b_v;
                for (int k = 1; k < SQRT_LAT; k++) r_l2_v[k] <= r_l2_v[k-1];
                r_d_v     <= r_l2_v[SQRT_LAT-1];
                r_cell_v  <= r_d_v;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_cell_v && out_free) r_out <= r_phase ? r_cell_second : r_cell_first;
        if (adv) begin
            r_l1_pole[0] <= i_head.pole;
            for (int k = 1; k < L1_LEN; k++) r_l1_pole[k] <= r_l1_pole[k-1];

            r_a_geo <= '{pole: r_l1_pole[L1_LEN-1], up: up, lo: lo,
                         ct0: ct0, st0: st0, ct1: ct1, st1: st1,
                         cp0: sc_p0.c, sp0: sc_p0.s, cp1: sc_p1.c, sp1: sc_p1.s};
            r_a_z   <= zsat;

            r_b_geo <= r_a_geo;
            r_b_rad <= (SQRT_W'(1) << (2 * FRAC_BITS)) - SQRT_W'(zsq);

            r_l2_geo[0] <= r_b_geo;
            for (int k = 1; k < SQRT_LAT; k++) r_l2_geo[k] <= r_l2_geo[k-1];

            r_d_pole <= g.pole;
            r_d_c0   <= c0;
            r_d_c1   <= c1;
            r_d_x00  <= s0 * g.cp0;
            r_d_y00  <= s0 * g.sp0;
            r_d_x01  <= s1 * g.cp0;
            r_d_y01  <= s1 * g.sp0;
            r_d_x10  <= s0 * g.cp1;
            r_d_y10  <= s0 * g.sp1;
            r_d_x11  <= s1 * g.cp1;
            r_d_y11  <= s1 * g.sp1;

            r_cell_two    <= !r_d_pole;
            r_cell_first  <= r_d_pole ? make_tri(v00, v01, v11, 1'b1)
                                      : make_tri(v00, v01, v10, 1'b0);
            r_cell_second <= make_tri(v10, v01, v11, 1'b1);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

@@ rtl/sphere_cell_triangulator.sv @@
// ----------------------------------------------------------------------------
// sphere_cell_triangulator: triangles for one cell of a unit UV sphere
// Each input beat names a polar band and an azimuth sector; the block returns
// zero, one or two triangle beats with Q2.14 vertices.
// ----------------------------------------------------------------------------
// A cell beat is taken on i_in_valid & o_in_ready; with an empty queue and no
// stall, o_out_valid then rises with one triangle beat for a pole band, two
// for an inner band, or none for an index outside the counts, a count of zero
// or above 1024, or a band lying wholly outside the z limits. last_of_cell
// marks a cell's final triangle. While i_out_ready is high, pole-band cells
// go through at one per cycle and inner-band cells as fast as their two
// triangles can leave: the output register moves one triangle per cycle and
// sets the pace. Latency is set by the 17-stage angle dividers, the 17-stage
// sine/cosine CORDICs and the 16-stage square root used when a band edge is
// moved onto a z limit. Config registers (index 0 polar bands, 1 azimuth
// sectors, 2 lower z limit, 3 upper z limit) are written through i_cfg_we
// and must only change while no cell is in flight.
// ----------------------------------------------------------------------------
module sphere_cell_triangulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  sct_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output sct_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [sct_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sct_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sct_pkg::*;

    t_cfg  cfg;
    t_cell push_cell, head;
    logic  push, pop, q_full, q_empty;

    // front: config and cell classification
    sct_front u_front (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_ready,
        .i_in_data,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .o_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cell   (push_cell)
    );

    // short queue lets front and back stall independently
    sct_queue u_queue (
        .i_clk,
        .i_rst_n,
        .i_push  (push),
        .i_cell  (push_cell),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    // back: geometry pipeline and triangle emitter
    sct_back u_back (
        .i_clk,
        .i_rst_n,
        .i_cfg     (cfg),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_out_valid,
        .i_out_ready,
        .o_out_data
    );

endmodule
